// ===== rtl/ipacl_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 ACL package
// Shared types, request codes and the prefix mask function of the
// first-match IPv4 access list.
// ----------------------------------------------------------------------------
`default_nettype none

package ipacl_pkg;

  localparam int ADDR_W = 32;
  localparam int PLEN_W = 6;

  localparam logic [PLEN_W-1:0] MAX_PLEN = 6'd32;

  // Request codes carried by req_type.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Status codes carried by the result.
  localparam logic STS_OK   = 1'b0;
  localparam logic STS_FULL = 1'b1;

  // One stored rule: base address, clamped prefix length, allow bit.
  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [PLEN_W-1:0] plen;
    logic              allow;
  } rule_t;

  localparam int RULE_W = $bits(rule_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept_add;
    logic accept_chk;
    logic scan;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic hit;
    logic exhausted;
  } sts_t;

  // Mask of the leading len bits; len is never above 32 once stored.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    logic [PLEN_W-1:0] sh;
    logic [ADDR_W-1:0] m;
    sh = MAX_PLEN - len;
    if (len == '0) begin
      m = '0;
    end else begin
      m = {ADDR_W{1'b1}} << sh;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ipacl_ram.sv =====
// ----------------------------------------------------------------------------
// IPv4 ACL generic RAM
// Simple dual-port memory: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/ipacl_ctrl.sv =====
// ----------------------------------------------------------------------------
// IPv4 ACL controller
// Sequences one transaction at a time: accept, rule scan for checks, and
// hand-over of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic            in_req_type,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire ipacl_pkg::sts_t sts,
  output ipacl_pkg::cmd_t      cmd
);

  import ipacl_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic       in_acc;
  logic       out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_vld_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req_type == REQ_ADD) begin
            cmd.accept_add = 1'b1;
            state_nxt      = S_FINISH;
          end else begin
            cmd.accept_chk = 1'b1;
            state_nxt      = sts.empty ? S_FINISH : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.hit || sts.exhausted) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (cmd.load_out) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;

endmodule

`default_nettype wire

// ===== rtl/ipacl_dp.sv =====
// ----------------------------------------------------------------------------
// IPv4 ACL datapath
// Rule memory, rule count, scan pointer, prefix compare and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipacl_dp #(
  parameter int MAX_RULES = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ipacl_pkg::cmd_t                cmd,
  output ipacl_pkg::sts_t                     sts,
  input  wire logic [ipacl_pkg::ADDR_W-1:0]   in_ip_address,
  input  wire logic [ipacl_pkg::PLEN_W-1:0]   in_prefix_length,
  input  wire logic                           in_rule_allows,
  output logic                                out_verdict_allow,
  output logic                                out_status
);

  import ipacl_pkg::*;

  localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RULES);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  idx_r;
  logic              pend_r;
  logic [ADDR_W-1:0] addr_r;
  logic              verdict_r;
  logic              status_r;
  logic              out_verdict_r;
  logic              out_status_r;

  logic              full;
  logic              wr_en;
  logic              rd_en;
  rule_t             wr_rule;
  rule_t             rd_rule;
  logic [RULE_W-1:0] rd_data;
  logic              match;

  assign full  = (count_r == CNT_MAX);
  assign wr_en = cmd.accept_add && !full;
  assign rd_en = cmd.scan && (idx_r != count_r);

  assign wr_rule.base  = in_ip_address;
  assign wr_rule.plen  = (in_prefix_length > MAX_PLEN) ? MAX_PLEN : in_prefix_length;
  assign wr_rule.allow = in_rule_allows;

  ipacl_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES),
    .AW    (IDX_W)
  ) u_rules (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (wr_rule),
    .rd_en   (rd_en),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_rule = rule_t'(rd_data);
  assign match   = ((rd_rule.base ^ addr_r) & prefix_mask(rd_rule.plen)) == '0;

  assign sts.empty     = (count_r == '0);
  assign sts.hit       = pend_r && match;
  assign sts.exhausted = pend_r && !match && (idx_r == count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      // Any new transaction drops the compare left over from the last scan.
      if (cmd.accept_chk || cmd.accept_add) begin
        pend_r <= 1'b0;
      end else if (cmd.scan) begin
        pend_r <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_add) begin
      verdict_r <= 1'b0;
      status_r  <= full ? STS_FULL : STS_OK;
    end else if (cmd.accept_chk) begin
      // No matching rule leaves the address allowed.
      verdict_r <= 1'b1;
      status_r  <= STS_OK;
      addr_r    <= in_ip_address;
      idx_r     <= '0;
    end else begin
      if (sts.hit) begin
        verdict_r <= rd_rule.allow;
      end
      if (rd_en) begin
        idx_r <= idx_r + 1'b1;
      end
    end
    if (cmd.load_out) begin
      out_verdict_r <= verdict_r;
      out_status_r  <= status_r;
    end
  end

  assign out_verdict_allow = out_verdict_r;
  assign out_status        = out_status_r;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("rule count above table depth");

  a_idx_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan || pend_r) |-> idx_r <= count_r)
    else $error("scan pointer ran past the stored rules");

  a_count_only_on_add : assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(count_r))
    else $error("rule count changed without an accepted add");
`endif

endmodule

`default_nettype wire

// ===== rtl/ipv4_prefix_acl_first_match.sv =====
// ----------------------------------------------------------------------------
// IPv4 prefix ACL, first match
// Ordered table of IPv4 prefix rules with append and first-match check.
// ----------------------------------------------------------------------------
// Each transaction is either an add, which appends a rule (address, prefix
// length clamped to 32, allow bit) at the end of the table, or a check, which
// walks the stored rules in the order they were added and returns the allow
// bit of the first rule whose leading prefix bits equal those of the address;
// with no matching rule, or an empty table, the address is allowed. An add
// into a full table is dropped and answered with status 1. The block handles
// one transaction at a time and takes the next one only after the result of
// the last has moved into the output register. A check reads the rule memory
// through its single registered read port, one rule per cycle, and stops at
// the first match or after the last stored rule; with an empty table no rule
// is read. The result sits in an output register, so a check can already run
// while the previous result still waits for the sink. Reset clears the rule
// count and the control state but not the table; entries of the table beyond
// the count are never read, so no clearing pass is needed.
`default_nettype none

module ipv4_prefix_acl_first_match #(
  parameter int MAX_RULES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Request channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_req_type,
  input  wire logic [ipacl_pkg::ADDR_W-1:0] in_ip_address,
  input  wire logic [ipacl_pkg::PLEN_W-1:0] in_prefix_length,
  input  wire logic                         in_rule_allows,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_verdict_allow,
  output logic                              out_status
);

  import ipacl_pkg::*;

  // Command and status buses between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller decides when a transaction is taken, how long the scan
  // runs and when the result moves into the output register.
  ipacl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // The datapath holds the rule memory, the count of stored rules, the scan
  // pointer and the prefix comparator, and it owns the result payload.
  ipacl_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_ip_address     (in_ip_address),
    .in_prefix_length  (in_prefix_length),
    .in_rule_allows    (in_rule_allows),
    .out_verdict_allow (out_verdict_allow),
    .out_status        (out_status)
  );

endmodule

`default_nettype wire
